/* sv/utf8vc_pkg.sv */
// ----------------------------------------------------------------------------
// utf8vc_pkg
// Shared types, constants and helpers of the UTF-8 validator and counter.
// ----------------------------------------------------------------------------
package utf8vc_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SHOW_BITS  = 16;
  localparam int unsigned LIMIT_BITS = 17;
  localparam int unsigned CMP_BITS   = (COUNT_BITS > SHOW_BITS) ? COUNT_BITS : SHOW_BITS;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TEXT_REQUIRED = 2'd0,
    CFG_MINIMUM_CHARS = 2'd1,
    CFG_MAXIMUM_CHARS = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] ASCII_MAX = 8'h7f;
  localparam logic [7:0] LEAD2_MIN = 8'hc2;
  localparam logic [7:0] LEAD2_MAX = 8'hdf;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD3_MAX = 8'hef;
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] LEAD4_MAX = 8'hf4;
  localparam logic [7:0] LEAD_E0   = 8'he0;
  localparam logic [7:0] LEAD_ED   = 8'hed;
  localparam logic [7:0] LEAD_F0   = 8'hf0;
  localparam logic [7:0] LEAD_F4   = 8'hf4;
  localparam logic [7:0] CONT_A0   = 8'ha0;
  localparam logic [7:0] CONT_90   = 8'h90;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  typedef struct packed {
    logic [1:0]            pending;
    logic [7:0]            lead;
    logic                  expect_second;
    logic                  error_seen;
    logic [COUNT_BITS-1:0] total;
    logic                  any_byte;
  } dec_state_t;

  typedef struct packed {
    logic                  text_required;
    logic [LIMIT_BITS-1:0] minimum_chars;
    logic [LIMIT_BITS-1:0] maximum_chars;
  } cfg_t;

  function automatic logic [SHOW_BITS-1:0] count_shown(input logic [COUNT_BITS-1:0] total);
    logic [CMP_BITS-1:0] ext;
    logic [CMP_BITS-1:0] top;
    ext = CMP_BITS'(total);
    top = CMP_BITS'({SHOW_BITS{1'b1}});
    if (ext > top) begin
      count_shown = {SHOW_BITS{1'b1}};
    end else begin
      count_shown = ext[SHOW_BITS-1:0];
    end
  endfunction

endpackage

/* sv/utf8vc_decode.sv */
// ----------------------------------------------------------------------------
// utf8vc_decode
// Next-state logic of the strict UTF-8 decoder for one byte.
// ----------------------------------------------------------------------------
module utf8vc_decode (
  input  utf8vc_pkg::dec_state_t cur_i,
  input  logic [7:0]             text_byte_i,
  input  logic                   byte_present_i,
  output utf8vc_pkg::dec_state_t nxt_o
);
  import utf8vc_pkg::*;

  logic [COUNT_BITS-1:0] bumped;
  logic                  bad_second;
  logic [7:0]            b;

  assign b = text_byte_i;
  assign bumped = (cur_i.total == {COUNT_BITS{1'b1}}) ? cur_i.total
                                                      : cur_i.total + COUNT_BITS'(1);
  assign bad_second = cur_i.expect_second &&
                      ((cur_i.lead == LEAD_E0 && b <  CONT_A0) ||
                       (cur_i.lead == LEAD_ED && b >= CONT_A0) ||
                       (cur_i.lead == LEAD_F0 && b <  CONT_90) ||
                       (cur_i.lead == LEAD_F4 && b >= CONT_90));

  always_comb begin
    nxt_o = cur_i;
    if (byte_present_i) begin
      nxt_o.any_byte = 1'b1;
      if (!cur_i.error_seen) begin
        if (cur_i.pending == 2'd0) begin
          if (b <= ASCII_MAX) begin
            nxt_o.total = bumped;
          end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            nxt_o.pending = 2'd1;
            nxt_o.lead = b;
            nxt_o.expect_second = 1'b1;
          end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            nxt_o.pending = 2'd2;
            nxt_o.lead = b;
            nxt_o.expect_second = 1'b1;
          end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            nxt_o.pending = 2'd3;
            nxt_o.lead = b;
            nxt_o.expect_second = 1'b1;
          end else begin
            nxt_o.error_seen = 1'b1;
          end
        end else if (b[7:6] != CONT_TAG || bad_second) begin
          nxt_o.error_seen = 1'b1;
        end else begin
          nxt_o.expect_second = 1'b0;
          nxt_o.pending = cur_i.pending - 2'd1;
          if (cur_i.pending == 2'd1) begin
            nxt_o.total = bumped;
          end
        end
      end
    end
  end

endmodule

/* sv/utf8vc_verdict.sv */
// ----------------------------------------------------------------------------
// utf8vc_verdict
// Final verdict of a string from its decoder state and the length limits.
// ----------------------------------------------------------------------------
module utf8vc_verdict (
  input  utf8vc_pkg::dec_state_t st_i,
  input  utf8vc_pkg::cfg_t       cfg_i,
  output logic                   accepted_o
);
  import utf8vc_pkg::*;

  logic [CMP_BITS-1:0] n;
  logic [CMP_BITS-1:0] lo;
  logic [CMP_BITS-1:0] hi;
  logic                below_min;
  logic                above_max;

  assign n  = CMP_BITS'(st_i.total);
  assign lo = CMP_BITS'(cfg_i.minimum_chars[LIMIT_BITS-2:0]);
  assign hi = CMP_BITS'(cfg_i.maximum_chars[LIMIT_BITS-2:0]);
  assign below_min = !cfg_i.minimum_chars[LIMIT_BITS-1] && (n < lo);
  assign above_max = !cfg_i.maximum_chars[LIMIT_BITS-1] && (n > hi);

  always_comb begin
    if (!st_i.any_byte) begin
      accepted_o = !cfg_i.text_required;
    end else if (st_i.error_seen || st_i.pending != 2'd0) begin
      accepted_o = 1'b0;
    end else begin
      accepted_o = !below_min && !above_max;
    end
  end

endmodule

/* sv/utf8_validate_and_count.sv */
// ----------------------------------------------------------------------------
// utf8_validate_and_count
// Strict UTF-8 validator with a saturating code point counter and limits.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  text_byte_i, byte_present_i, end_of_text_i
// out      output     out_valid_o/out_stall_i accepted_o, code_point_count_o
// cfg      input      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One request is taken every cycle while the input is not stalled; an end request
// is held in the input register, and its verdict then goes to the result register.
// Reset clears the decoder state and loads the limits with no limit.
// A stalled result holds a following end request in the input register, and the
// input stalls behind it; byte requests ahead of that end request keep flowing.
module utf8_validate_and_count (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           text_byte_i,
  input  logic                                 byte_present_i,
  input  logic                                 end_of_text_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 accepted_o,
  output logic [utf8vc_pkg::SHOW_BITS-1:0]     code_point_count_o,
  input  logic                                 cfg_we_i,
  input  logic [utf8vc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [utf8vc_pkg::LIMIT_BITS-1:0]    cfg_wdata_i
);
  import utf8vc_pkg::*;

  cfg_t       cfg_q;
  dec_state_t st_q, st_d, st_nxt;
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       present_q;
  logic       end_q;
  logic       res_vld_q;
  logic       res_acc_q;
  logic [SHOW_BITS-1:0] res_cnt_q;
  logic       verdict;
  logic       advance;
  logic       take_in;

  assign advance    = in_vld_q && (!end_q || !res_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_required <= 1'b0;
      cfg_q.minimum_chars <= {LIMIT_BITS{1'b1}};
      cfg_q.maximum_chars <= {LIMIT_BITS{1'b1}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEXT_REQUIRED: cfg_q.text_required <= cfg_wdata_i[0];
        CFG_MINIMUM_CHARS: cfg_q.minimum_chars <= cfg_wdata_i;
        CFG_MAXIMUM_CHARS: cfg_q.maximum_chars <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take_in || advance) begin
      in_vld_q <= take_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      byte_q    <= text_byte_i;
      present_q <= byte_present_i;
      end_q     <= end_of_text_i;
    end
  end

  utf8vc_decode u_decode (
    .cur_i          (st_q),
    .text_byte_i    (byte_q),
    .byte_present_i (present_q),
    .nxt_o          (st_nxt)
  );

  utf8vc_verdict u_verdict (
    .st_i       (st_nxt),
    .cfg_i      (cfg_q),
    .accepted_o (verdict)
  );

  always_comb begin
    st_d = st_q;
    if (advance) begin
      st_d = end_q ? '0 : st_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance && end_q) begin
      res_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && end_q) begin
      res_acc_q <= verdict;
      res_cnt_q <= count_shown(st_nxt.total);
    end
  end

  assign out_valid_o        = res_vld_q;
  assign accepted_o         = res_acc_q;
  assign code_point_count_o = res_cnt_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && end_q && res_vld_q))
    else $error("input stalled without a blocked end request");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && end_q) |=> (st_q == '0))
    else $error("decoder state not cleared after a verdict");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(advance && end_q))
    else $error("result appeared without an end request");

endmodule

/* sim/utf8_validate_and_count_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validate_and_count_tb
// Drives byte strings into the UTF-8 validator under several limit settings
// and checks every verdict and count against a cycle-free decoder model kept
// in the bench. A short directed pass covers the boundary encodings, then
// random strings, mostly well formed, run with random gaps and stalls.
// ----------------------------------------------------------------------------
module utf8_validate_and_count_tb;
  import utf8vc_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum int {END_SEPARATE, END_ON_BYTE, END_RANDOM} end_mode_e;

  typedef struct {
    logic [7:0] data_byte;
    logic       present;
    logic       eot;
  } text_item_t;

  typedef struct {
    logic                 ok;
    logic [SHOW_BITS-1:0] count;
  } verdict_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              text_byte_i = 8'h00;
  logic                    byte_present_i = 1'b0;
  logic                    end_of_text_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    accepted_o;
  logic [SHOW_BITS-1:0]    code_point_count_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [LIMIT_BITS-1:0]   cfg_wdata_i = '0;

  text_item_t text_items[$];
  verdict_t   verdicts_due[$];
  logic [7:0] str_bytes[$];
  text_item_t next_item;
  verdict_t   due_v;
  verdict_t   got_v;

  logic                  need_text = 1'b0;
  logic [LIMIT_BITS-1:0] min_chars = '1;
  logic [LIMIT_BITS-1:0] max_chars = '1;

  logic [1:0]            pend_bytes = '0;
  logic [7:0]            seq_lead = '0;
  logic                  want_second = 1'b0;
  logic                  bad_seq = 1'b0;
  logic [COUNT_BITS-1:0] cp_total = '0;
  logic                  saw_byte = 1'b0;

  int cycle_count = 0;
  int results_seen = 0;
  int fail_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  utf8_validate_and_count dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .text_byte_i        (text_byte_i),
    .byte_present_i     (byte_present_i),
    .end_of_text_i      (end_of_text_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .accepted_o         (accepted_o),
    .code_point_count_o (code_point_count_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic bit quiet_window();
    return cycle_count >= 1000 && cycle_count < 3000;
  endfunction

  function automatic bit side_rests();
    return !quiet_window() && $urandom_range(0, 99) < 31;
  endfunction

  function automatic void clear_decoder();
    pend_bytes  = '0;
    seq_lead    = '0;
    want_second = 1'b0;
    bad_seq     = 1'b0;
    cp_total    = '0;
    saw_byte    = 1'b0;
  endfunction

  function automatic void bump_total();
    if (cp_total != {COUNT_BITS{1'b1}}) begin
      cp_total = cp_total + 1'b1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    saw_byte = 1'b1;
    if (bad_seq) begin
      return;
    end
    if (pend_bytes == 2'd0) begin
      if (b <= ASCII_MAX) begin
        bump_total();
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        pend_bytes = 2'd1;
        seq_lead = b;
        want_second = 1'b1;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        pend_bytes = 2'd2;
        seq_lead = b;
        want_second = 1'b1;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        pend_bytes = 2'd3;
        seq_lead = b;
        want_second = 1'b1;
      end else begin
        bad_seq = 1'b1;
      end
      return;
    end
    if (b[7:6] != CONT_TAG) begin
      bad_seq = 1'b1;
      return;
    end
    if (want_second) begin
      if ((seq_lead == LEAD_E0 && b < CONT_A0) || (seq_lead == LEAD_ED && b >= CONT_A0) ||
          (seq_lead == LEAD_F0 && b < CONT_90) || (seq_lead == LEAD_F4 && b >= CONT_90)) begin
        bad_seq = 1'b1;
        return;
      end
      want_second = 1'b0;
    end
    pend_bytes = pend_bytes - 1'b1;
    if (pend_bytes == 2'd0) begin
      bump_total();
    end
  endfunction

  function automatic logic string_verdict();
    if (!saw_byte) begin
      return !need_text;
    end
    if (bad_seq || pend_bytes != 2'd0) begin
      return 1'b0;
    end
    if (!min_chars[LIMIT_BITS-1] && {1'b0, cp_total} < min_chars) begin
      return 1'b0;
    end
    if (!max_chars[LIMIT_BITS-1] && {1'b0, cp_total} > max_chars) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Request driver and decoder prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      clear_decoder();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (byte_present_i) begin
          decode_byte(text_byte_i);
        end
        if (end_of_text_i) begin
          due_v.ok    = string_verdict();
          due_v.count = count_shown(cp_total);
          verdicts_due.insert(verdicts_due.size(), due_v);
          clear_decoder();
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (text_items.size() != 0 && !side_rests()) begin
          next_item = text_items.pop_front();
          in_valid_i     <= 1'b1;
          text_byte_i    <= next_item.data_byte;
          byte_present_i <= next_item.present;
          end_of_text_i  <= next_item.eot;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result stall, with one long hold-off so that the input backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && results_seen >= 30) begin
      hold_done   <= 1'b1;
      hold_left   <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= side_rests();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result: accepted %0d, code_point_count %0d",
               accepted_o, code_point_count_o);
        fail_count++;
      end else begin
        got_v = verdicts_due.pop_front();
        if (accepted_o !== got_v.ok) begin
          $error("accepted: expected %0d, actual %0d", got_v.ok, accepted_o);
          fail_count++;
        end
        if (code_point_count_o !== got_v.count) begin
          $error("code_point_count: expected %0d, actual %0d",
                 got_v.count, code_point_count_o);
          fail_count++;
        end
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic present, input logic eot);
    text_item_t it;
    it.data_byte = b;
    it.present   = present;
    it.eot       = eot;
    text_items.insert(text_items.size(), it);
  endtask

  task automatic emit_string(input end_mode_e mode);
    bit on_byte;
    on_byte = str_bytes.size() != 0 &&
              (mode == END_ON_BYTE || (mode == END_RANDOM && $urandom_range(0, 1) == 1));
    foreach (str_bytes[i]) begin
      if (mode == END_RANDOM && $urandom_range(0, 19) == 0) begin
        push_item(8'($urandom), 1'b0, 1'b0);
      end
      push_item(str_bytes[i], 1'b1, on_byte && i == str_bytes.size() - 1);
    end
    if (!on_byte) begin
      push_item(8'($urandom), 1'b0, 1'b1);
    end
    str_bytes.delete();
  endtask

  task automatic append_byte(input logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endtask

  task automatic add_byte(input int lo, input int hi);
    append_byte(8'($urandom_range(lo, hi)));
  endtask

  task automatic add_code_point();
    logic [7:0] lead;
    case ($urandom_range(0, 3))
      0: add_byte(8'h00, 8'h7f);
      1: begin
        add_byte(8'hc2, 8'hdf);
        add_byte(8'h80, 8'hbf);
      end
      2: begin
        lead = 8'($urandom_range(8'he0, 8'hef));
        append_byte(lead);
        if (lead == LEAD_E0) begin
          add_byte(8'ha0, 8'hbf);
        end else if (lead == LEAD_ED) begin
          add_byte(8'h80, 8'h9f);
        end else begin
          add_byte(8'h80, 8'hbf);
        end
        add_byte(8'h80, 8'hbf);
      end
      default: begin
        lead = 8'($urandom_range(8'hf0, 8'hf4));
        append_byte(lead);
        if (lead == LEAD_F0) begin
          add_byte(8'h90, 8'hbf);
        end else if (lead == LEAD_F4) begin
          add_byte(8'h80, 8'h8f);
        end else begin
          add_byte(8'h80, 8'hbf);
        end
        add_byte(8'h80, 8'hbf);
        add_byte(8'h80, 8'hbf);
      end
    endcase
  endtask

  task automatic add_defect();
    int         pick;
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: begin
        pick = $urandom_range(0, 12);
        append_byte(pick < 2 ? 8'(8'hc0 + pick) : 8'(8'hf5 + pick - 2));
      end
      1: begin
        add_byte(8'hc2, 8'hf4);
        do begin
          b = 8'($urandom);
        end while (b[7:6] == CONT_TAG);
        append_byte(b);
      end
      2: begin
        if ($urandom_range(0, 1) == 1) begin
          append_byte(LEAD_E0);
          add_byte(8'h80, 8'h9f);
        end else begin
          append_byte(LEAD_F0);
          add_byte(8'h80, 8'h8f);
        end
      end
      3: begin
        append_byte(LEAD_ED);
        add_byte(8'ha0, 8'hbf);
      end
      4: begin
        append_byte(LEAD_F4);
        add_byte(8'h90, 8'hbf);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: add_byte(8'hc2, 8'hdf);
          1: begin
            add_byte(8'he1, 8'hec);
            repeat ($urandom_range(0, 1)) add_byte(8'h80, 8'hbf);
          end
          default: begin
            add_byte(8'hf1, 8'hf3);
            repeat ($urandom_range(0, 2)) add_byte(8'h80, 8'hbf);
          end
        endcase
        return;
      end
    endcase
    repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
  endtask

  task automatic build_random_string();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      repeat ($urandom_range(0, 10)) add_code_point();
    end else if (kind < 85) begin
      repeat ($urandom_range(0, 3)) add_code_point();
      add_defect();
    end else begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
    end
    emit_string(END_RANDOM);
  endtask

  task automatic wait_for_idle();
    do begin
      @(negedge clk_i);
    end while (text_items.size() != 0 || in_valid_i || verdicts_due.size() != 0);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [LIMIT_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TEXT_REQUIRED: need_text = data[0];
      CFG_MINIMUM_CHARS: min_chars = data;
      CFG_MAXIMUM_CHARS: max_chars = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic need, input logic [LIMIT_BITS-1:0] lo,
                           input logic [LIMIT_BITS-1:0] hi);
    write_reg(CFG_TEXT_REQUIRED, {16'($urandom), need});
    write_reg(CFG_MINIMUM_CHARS, lo);
    write_reg(CFG_MAXIMUM_CHARS, hi);
    write_reg(CFG_UNUSED_IDX, 17'($urandom));
    @(negedge clk_i);
  endtask

  task automatic random_phase();
    while (text_items.size() < 155) begin
      build_random_string();
    end
    wait_for_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    emit_string(END_SEPARATE);
    str_bytes = '{8'h00};
    emit_string(END_ON_BYTE);
    str_bytes = '{8'h7f, 8'hdf, 8'hbf, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
    emit_string(END_ON_BYTE);
    str_bytes = '{8'he0, 8'h9f, 8'h80};
    emit_string(END_ON_BYTE);
    str_bytes = '{8'hed, 8'ha0};
    emit_string(END_SEPARATE);
    str_bytes = '{8'hf0, 8'h8f};
    emit_string(END_ON_BYTE);
    str_bytes = '{8'hf4, 8'h90};
    emit_string(END_ON_BYTE);
    str_bytes = '{8'hc0};
    emit_string(END_ON_BYTE);
    str_bytes = '{8'hff};
    emit_string(END_SEPARATE);
    push_item(8'he1, 1'b1, 1'b0);
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'ha5, 1'b0, 1'b1);
    str_bytes = '{8'hc2, 8'h41};
    emit_string(END_ON_BYTE);
    wait_for_idle();

    configure(1'b1, '1, '1);
    random_phase();
    configure(1'b0, 17'd0, 17'd0);
    random_phase();
    configure(1'b1, 17'd3, 17'd8);
    random_phase();
    configure(1'b0, 17'd65535, 17'd65535);
    random_phase();
    configure(1'($urandom), 17'($urandom_range(0, 6)), 17'($urandom_range(2, 12)));
    random_phase();
    configure(1'b0, 17'h10000, {1'b1, 16'($urandom)});
    random_phase();
    configure(1'b1, 17'd5, 17'd2);
    random_phase();
    configure(1'b0, 17'($urandom_range(0, 4)), 17'd65535);
    random_phase();

    configure(1'($urandom), 17'($urandom_range(0, 10)), 17'($urandom_range(0, 10)));
    random_phase();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && verdicts_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
sv/utf8vc_pkg.sv
sv/utf8vc_decode.sv
sv/utf8vc_verdict.sv
sv/utf8_validate_and_count.sv
sim/utf8_validate_and_count_tb.sv
